/* hdl/gbr_pkg.sv */
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared types, widths and helpers of the separable Gaussian blur.
// ----------------------------------------------------------------------------
package gbr_pkg;

	localparam int RADIUS_DEF     = 3;
	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int DESC_DEPTH     = 4;
	localparam int RES_DEPTH      = 4;

	localparam int DIM_W    = 13;
	localparam int WT_W     = 17;
	localparam int CH_W     = 8;
	localparam int PIX_W    = 3 * CH_W;
	localparam int POS_W    = 12;
	localparam int NUM_TREG = 4;
	localparam int TREG_AW  = 2;

	// Each weight is below 2^17, so a total of seven taps stays below 2^20.
	localparam int SUM_W  = 20;
	localparam int V_W    = SUM_W + CH_W;
	localparam int NUM_W  = 2 * SUM_W + CH_W;
	localparam int DEN_W  = 2 * SUM_W;
	localparam int REM_W  = NUM_W + 1;
	localparam int QB     = 9;
	localparam int QIDX_W = 4;

	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [WT_W-1:0]  TAP_CENTER_RST   = 17'd65536;
	localparam logic [WT_W-1:0]  TAP_ONE_RST      = 17'd39750;
	localparam logic [WT_W-1:0]  TAP_TWO_RST      = 17'd8869;
	localparam logic [WT_W-1:0]  TAP_THREE_RST    = 17'd728;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_TAP_CENTER   = 3'd2,
		REG_TAP_ONE      = 3'd3,
		REG_TAP_TWO      = 3'd4,
		REG_TAP_THREE    = 3'd5
	} reg_idx_t;

	typedef logic [NUM_TREG-1:0][WT_W-1:0] taps_t;

	typedef struct packed {
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} res_t;

	function automatic logic [WT_W-1:0] tap_wt(input taps_t taps, input logic [31:0] tap_dist);
		logic [WT_W-1:0] w;
		w = '0;
		if (tap_dist < 32'(NUM_TREG)) begin
			w = taps[tap_dist[TREG_AW-1:0]];
		end
		return w;
	endfunction

endpackage

/* hdl/gbr_fifo.sv */
// ----------------------------------------------------------------------------
// gbr_fifo
// Small synchronous queue with registered storage and a count.
// ----------------------------------------------------------------------------
module gbr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = data_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* hdl/gbr_front.sv */
// ----------------------------------------------------------------------------
// gbr_front
// Tracks the raster position of incoming words and classifies each one.
// ----------------------------------------------------------------------------
module gbr_front #(
	parameter int RADIUS     = gbr_pkg::RADIUS_DEF,
	parameter int MAX_WIDTH  = gbr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gbr_pkg::MAX_HEIGHT_DEF,
	parameter int DESC_W     = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [gbr_pkg::CH_W-1:0]            red_in,
	input  logic [gbr_pkg::CH_W-1:0]            green_in,
	input  logic [gbr_pkg::CH_W-1:0]            blue_in,
	input  logic                                geom_wr,
	input  logic [$clog2(MAX_WIDTH + 1)-1:0]    w_eff,
	input  logic [$clog2(MAX_HEIGHT + 1)-1:0]   h_eff,
	input  logic                                q_full,
	output logic                                q_push,
	output logic [DESC_W-1:0]                   desc
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT + RADIUS);
	localparam int SW = $clog2(2 * RADIUS);

	typedef struct packed {
		logic [gbr_pkg::PIX_W-1:0] pix;
		logic [RW-1:0]             row;
		logic [CW-1:0]             col;
		logic [SW-1:0]             slot;
		logic [CW-1:0]             first_j;
		logic [CW-1:0]             last_j;
		logic                      emits;
		logic                      store;
		logic                      has_out;
	} desc_t;

	logic [RW-1:0] in_row_q;
	logic [CW-1:0] in_col_q;
	logic [SW-1:0] slot_q;
	logic          accept;
	logic          last_col;
	logic [31:0]   c32;
	logic [31:0]   r32;
	desc_t         d;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_push = accept;
	assign desc   = d;

	always_comb begin
		c32      = 32'(in_col_q);
		r32      = 32'(in_row_q);
		last_col = (c32 + 32'd1 == 32'(w_eff));
		d.pix    = {blue_in, green_in, red_in};
		d.row    = in_row_q;
		d.col    = in_col_q;
		d.slot   = slot_q;
		d.emits  = (r32 >= 32'(RADIUS));
		d.store  = (r32 < 32'(h_eff));
		d.has_out = last_col || (c32 >= 32'(RADIUS));
		d.last_j = last_col ? in_col_q : CW'(c32 - 32'(RADIUS));
		if (c32 >= 32'(RADIUS)) begin
			d.first_j = CW'(c32 - 32'(RADIUS));
		end else begin
			d.first_j = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
			slot_q   <= '0;
		end else if (geom_wr) begin
			in_row_q <= '0;
			in_col_q <= '0;
			slot_q   <= '0;
		end else if (accept) begin
			if (last_col) begin
				in_col_q <= '0;
				if (r32 + 32'd1 >= 32'(h_eff) + 32'(RADIUS)) begin
					in_row_q <= '0;
					slot_q   <= '0;
				end else begin
					in_row_q <= in_row_q + 1'b1;
					slot_q   <= (slot_q == SW'(2 * RADIUS - 1)) ? '0 : slot_q + 1'b1;
				end
			end else begin
				in_col_q <= in_col_q + 1'b1;
			end
		end
	end

endmodule

/* hdl/gbr_back.sv */
// ----------------------------------------------------------------------------
// gbr_back
// Runs the vertical and horizontal passes, the line store and the divider.
// ----------------------------------------------------------------------------
module gbr_back #(
	parameter int RADIUS     = gbr_pkg::RADIUS_DEF,
	parameter int MAX_WIDTH  = gbr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gbr_pkg::MAX_HEIGHT_DEF,
	parameter int DESC_W     = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              desc_valid,
	input  logic [DESC_W-1:0]                 desc,
	output logic                              desc_pop,
	input  gbr_pkg::taps_t                    taps,
	input  logic [$clog2(MAX_HEIGHT + 1)-1:0] h_eff,
	input  logic                              res_full,
	output logic                              res_push,
	output gbr_pkg::res_t                     res
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT + RADIUS);
	localparam int SW    = $clog2(2 * RADIUS);
	localparam int TAPS  = 2 * RADIUS + 1;
	localparam int KW    = $clog2(TAPS);
	localparam int DEPTH = 2 * RADIUS * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);

	typedef struct packed {
		logic [gbr_pkg::PIX_W-1:0] pix;
		logic [RW-1:0]             row;
		logic [CW-1:0]             col;
		logic [SW-1:0]             slot;
		logic [CW-1:0]             first_j;
		logic [CW-1:0]             last_j;
		logic                      emits;
		logic                      store;
		logic                      has_out;
	} desc_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_VERT, ST_VWAIT, ST_STORE, ST_HORZ, ST_HWAIT,
		ST_DEN, ST_PREP, ST_DIV, ST_PUSH
	} state_t;

	state_t                           state_q;
	logic [KW-1:0]                    tap_q;
	logic [gbr_pkg::QIDX_W-1:0]       idx_q;
	logic [CW-1:0]                    j_q;
	logic                             v_valid_s1;
	logic                             v_valid_s2;
	logic                             h_valid_s1;

	desc_t                            din;
	desc_t                            cur_q;
	logic [gbr_pkg::PIX_W-1:0]        mem [DEPTH];
	logic [gbr_pkg::PIX_W-1:0]        mem_rd_q;
	logic                             mem_re;
	logic                             mem_we;
	logic [AW-1:0]                    rd_addr;
	logic [AW-1:0]                    wr_addr;

	logic [gbr_pkg::WT_W-1:0]         v_wt_s1;
	logic                             v_pix_s1;
	logic                             v_in_s1;
	logic [2:0][gbr_pkg::V_W-1:0]     v_prod_s2;
	logic [gbr_pkg::WT_W-1:0]         v_wt_s2;
	logic [2:0][gbr_pkg::V_W-1:0]     v_acc_q;
	logic [gbr_pkg::SUM_W-1:0]        sv_q;
	logic [2:0][gbr_pkg::V_W-1:0]     win_q [TAPS];
	logic [gbr_pkg::SUM_W-1:0]        rsum_q;

	logic [2:0][gbr_pkg::NUM_W-1:0]   h_prod_s1;
	logic [gbr_pkg::WT_W-1:0]         h_wt_s1;
	logic [2:0][gbr_pkg::NUM_W-1:0]   h_acc_q;
	logic [gbr_pkg::SUM_W-1:0]        sh_q;
	logic [gbr_pkg::DEN_W-1:0]        den_q;
	logic [2:0][gbr_pkg::REM_W-1:0]   rem_q;
	logic [2:0][gbr_pkg::QB-1:0]      quo_q;

	logic [31:0]                      ssum;
	logic [31:0]                      sq;
	logic [31:0]                      rt;
	logic [31:0]                      tap_dist;
	logic [31:0]                      ju;
	logic [31:0]                      hk32;
	logic [31:0]                      row32;
	logic [31:0]                      col32;
	logic                             v_in;
	logic                             h_in;
	logic [gbr_pkg::WT_W-1:0]         v_wt;
	logic [gbr_pkg::WT_W-1:0]         h_wt;
	logic [KW-1:0]                    hk;
	logic [2:0][gbr_pkg::V_W-1:0]     win_sel;
	logic [gbr_pkg::PIX_W-1:0]        v_data;
	logic [gbr_pkg::REM_W-1:0]        dsh;
	logic                             last_tap;
	logic [2:0][gbr_pkg::CH_W-1:0]    chan;

	assign din      = desc_t'(desc);
	assign desc_pop = (state_q == ST_IDLE) && desc_valid;
	assign res_push = (state_q == ST_PUSH) && !res_full;
	assign last_tap = (tap_q == KW'(2 * RADIUS));
	assign mem_re   = (state_q == ST_VERT) && v_in && !last_tap;
	assign mem_we   = (state_q == ST_STORE) && cur_q.store;

	always_comb begin
		ssum     = 32'(cur_q.slot) + 32'(tap_q);
		sq       = (ssum >= 32'(2 * RADIUS)) ? ssum - 32'(2 * RADIUS) : ssum;
		rt       = 32'(cur_q.row) + 32'(tap_q);
		v_in     = (rt >= 32'(2 * RADIUS)) && (rt < 32'(h_eff) + 32'(2 * RADIUS));
		tap_dist = (32'(tap_q) >= 32'(RADIUS)) ? 32'(tap_q) - 32'(RADIUS)
		                                       : 32'(RADIUS) - 32'(tap_q);
		v_wt     = v_in ? gbr_pkg::tap_wt(taps, tap_dist) : '0;
		rd_addr  = AW'(sq * 32'(MAX_WIDTH) + 32'(cur_q.col));
		wr_addr  = AW'(32'(cur_q.slot) * 32'(MAX_WIDTH) + 32'(cur_q.col));
		ju       = 32'(j_q) + 32'(tap_q);
		h_in     = (ju >= 32'(RADIUS)) && (ju <= 32'(cur_q.col) + 32'(RADIUS));
		hk32     = 32'(cur_q.col) + 32'(RADIUS) - ju;
		hk       = h_in ? KW'(hk32) : '0;
		h_wt     = h_in ? gbr_pkg::tap_wt(taps, tap_dist) : '0;
		win_sel  = h_in ? win_q[hk] : '0;
		v_data   = v_in_s1 ? (v_pix_s1 ? cur_q.pix : mem_rd_q) : '0;
		dsh      = gbr_pkg::REM_W'(den_q) << idx_q;
		row32    = 32'(cur_q.row) - 32'(RADIUS);
		col32    = 32'(j_q);
		for (int i = 0; i < 3; i++) begin
			if (den_q == '0) begin
				chan[i] = '0;
			end else if (quo_q[i][gbr_pkg::QB-1]) begin
				chan[i] = '1;
			end else begin
				chan[i] = quo_q[i][gbr_pkg::CH_W-1:0];
			end
		end
		res.red   = chan[0];
		res.green = chan[1];
		res.blue  = chan[2];
		res.row   = row32[gbr_pkg::POS_W-1:0];
		res.col   = col32[gbr_pkg::POS_W-1:0];
		res.last  = (j_q == cur_q.last_j);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tap_q      <= '0;
			idx_q      <= '0;
			j_q        <= '0;
			v_valid_s1 <= 1'b0;
			v_valid_s2 <= 1'b0;
			h_valid_s1 <= 1'b0;
		end else begin
			v_valid_s1 <= (state_q == ST_VERT);
			v_valid_s2 <= v_valid_s1;
			h_valid_s1 <= (state_q == ST_HORZ);
			unique case (state_q)
				ST_IDLE: begin
					if (desc_valid) begin
						tap_q   <= '0;
						state_q <= din.emits ? ST_VERT : ST_STORE;
					end
				end
				ST_VERT: begin
					if (last_tap) begin
						state_q <= ST_VWAIT;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				ST_VWAIT: begin
					if (!v_valid_s1 && !v_valid_s2) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (cur_q.emits && cur_q.has_out) begin
						j_q     <= cur_q.first_j;
						tap_q   <= '0;
						state_q <= ST_HORZ;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_HORZ: begin
					if (last_tap) begin
						state_q <= ST_HWAIT;
					end else begin
						tap_q <= tap_q + 1'b1;
					end
				end
				ST_HWAIT: begin
					if (!h_valid_s1) begin
						state_q <= ST_DEN;
					end
				end
				ST_DEN: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					idx_q   <= gbr_pkg::QIDX_W'(gbr_pkg::QB - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (idx_q == '0) begin
						state_q <= ST_PUSH;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_PUSH: begin
					if (!res_full) begin
						if (j_q == cur_q.last_j) begin
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + 1'b1;
							tap_q   <= '0;
							state_q <= ST_HORZ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (desc_pop) begin
			cur_q   <= din;
			v_acc_q <= '0;
			sv_q    <= '0;
		end
		v_wt_s1  <= v_wt;
		v_pix_s1 <= last_tap;
		v_in_s1  <= v_in;
		v_wt_s2  <= v_wt_s1;
		for (int i = 0; i < 3; i++) begin
			v_prod_s2[i] <= gbr_pkg::V_W'(v_wt_s1) *
			                gbr_pkg::V_W'(v_data[gbr_pkg::CH_W*i +: gbr_pkg::CH_W]);
			h_prod_s1[i] <= gbr_pkg::NUM_W'(h_wt) * gbr_pkg::NUM_W'(win_sel[i]);
		end
		h_wt_s1 <= h_wt;
		if (v_valid_s2) begin
			for (int i = 0; i < 3; i++) begin
				v_acc_q[i] <= v_acc_q[i] + v_prod_s2[i];
			end
			sv_q <= sv_q + gbr_pkg::SUM_W'(v_wt_s2);
		end
		if (h_valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				h_acc_q[i] <= h_acc_q[i] + h_prod_s1[i];
			end
			sh_q <= sh_q + gbr_pkg::SUM_W'(h_wt_s1);
		end
		if (state_q == ST_STORE) begin
			h_acc_q <= '0;
			sh_q    <= '0;
			if (cur_q.emits) begin
				for (int k = TAPS - 1; k > 0; k--) begin
					win_q[k] <= win_q[k-1];
				end
				win_q[0] <= v_acc_q;
				rsum_q   <= sv_q;
			end
		end
		if (res_push) begin
			h_acc_q <= '0;
			sh_q    <= '0;
		end
		if (state_q == ST_DEN) begin
			den_q <= gbr_pkg::DEN_W'(rsum_q) * gbr_pkg::DEN_W'(sh_q);
		end
		if (state_q == ST_PREP) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= gbr_pkg::REM_W'(h_acc_q[i]) + gbr_pkg::REM_W'(den_q >> 1);
				quo_q[i] <= '0;
			end
		end
		if (state_q == ST_DIV) begin
			for (int i = 0; i < 3; i++) begin
				if (rem_q[i] >= dsh) begin
					rem_q[i]        <= rem_q[i] - dsh;
					quo_q[i][idx_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= cur_q.pix;
		end
		if (mem_re) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	a_vert_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STORE) |-> (!v_valid_s1 && !v_valid_s2))
		else $error("line store updated before the vertical sum finished");

	a_den_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |=> $stable(den_q))
		else $error("divisor changed during division");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		desc_pop |=> (state_q == ST_VERT || state_q == ST_STORE))
		else $error("descriptor taken without starting work");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.last) |=> (state_q == ST_IDLE))
		else $error("work continued after the last result of a word");

endmodule

/* hdl/separable_gaussian_blur_renorm.sv */
// The back end takes a word the cycle after it is accepted when it is idle. A word outside
// the output rows only passes the store step; a word in an output row runs the vertical
// pass, then per result the taps, product, 9-step divide and push (held on a full queue).
// The single back-end sequencer takes no new word until it has finished the last one.
// Reset clears the position counters, queues and sequencer and loads the register defaults;
// the line store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// separable_gaussian_blur_renorm
// Streaming separable Gaussian blur with renormalization at the image borders.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_renorm #(
	parameter int RADIUS     = gbr_pkg::RADIUS_DEF,
	parameter int MAX_WIDTH  = gbr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gbr_pkg::MAX_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        req_type,
	input  logic [gbr_pkg::CH_W-1:0]    red_in,
	input  logic [gbr_pkg::CH_W-1:0]    green_in,
	input  logic [gbr_pkg::CH_W-1:0]    blue_in,
	output logic                        empty,
	input  logic                        pop,
	output logic [gbr_pkg::CH_W-1:0]    red_out,
	output logic [gbr_pkg::CH_W-1:0]    green_out,
	output logic [gbr_pkg::CH_W-1:0]    blue_out,
	output logic [gbr_pkg::POS_W-1:0]   out_row,
	output logic [gbr_pkg::POS_W-1:0]   out_col,
	output logic                        last_of_run,
	input  logic                        cfg_wr_en,
	input  logic [2:0]                  cfg_index,
	input  logic [gbr_pkg::WT_W-1:0]    cfg_data
);

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int RW     = $clog2(MAX_HEIGHT + RADIUS);
	localparam int SW     = $clog2(2 * RADIUS);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int DESC_W = gbr_pkg::PIX_W + RW + 3 * CW + SW + 3;
	localparam int RES_W  = $bits(gbr_pkg::res_t);

	logic [gbr_pkg::DIM_W-1:0] frame_width_q;
	logic [gbr_pkg::DIM_W-1:0] frame_height_q;
	gbr_pkg::taps_t            taps_q;
	logic                      geom_wr;
	logic [31:0]               fw32;
	logic [31:0]               fh32;
	logic [WW-1:0]             w_eff;
	logic [HW-1:0]             h_eff;

	logic                      dq_push;
	logic                      dq_full;
	logic                      dq_empty;
	logic                      dq_pop;
	logic [DESC_W-1:0]         dq_wdata;
	logic [DESC_W-1:0]         dq_rdata;

	logic                      rq_push;
	logic                      rq_full;
	gbr_pkg::res_t             rq_wdata;
	gbr_pkg::res_t             rq_head;
	logic [RES_W-1:0]          rq_rdata;

	assign geom_wr = cfg_wr_en && (cfg_index == gbr_pkg::REG_FRAME_WIDTH ||
	                               cfg_index == gbr_pkg::REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= gbr_pkg::FRAME_WIDTH_RST;
			frame_height_q <= gbr_pkg::FRAME_HEIGHT_RST;
			taps_q[0]      <= gbr_pkg::TAP_CENTER_RST;
			taps_q[1]      <= gbr_pkg::TAP_ONE_RST;
			taps_q[2]      <= gbr_pkg::TAP_TWO_RST;
			taps_q[3]      <= gbr_pkg::TAP_THREE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				gbr_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[gbr_pkg::DIM_W-1:0];
				gbr_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[gbr_pkg::DIM_W-1:0];
				gbr_pkg::REG_TAP_CENTER:   taps_q[0]      <= cfg_data;
				gbr_pkg::REG_TAP_ONE:      taps_q[1]      <= cfg_data;
				gbr_pkg::REG_TAP_TWO:      taps_q[2]      <= cfg_data;
				gbr_pkg::REG_TAP_THREE:    taps_q[3]      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		fw32 = 32'(frame_width_q);
		fh32 = 32'(frame_height_q);
		if (fw32 == 32'd0) begin
			w_eff = WW'(1);
		end else if (fw32 > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fw32);
		end
		if (fh32 == 32'd0) begin
			h_eff = HW'(1);
		end else if (fh32 > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(fh32);
		end
	end

	gbr_front #(
		.RADIUS     (RADIUS),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.DESC_W     (DESC_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.geom_wr  (geom_wr),
		.w_eff    (w_eff),
		.h_eff    (h_eff),
		.q_full   (dq_full),
		.q_push   (dq_push),
		.desc     (dq_wdata)
	);

	gbr_fifo #(
		.WIDTH (DESC_W),
		.DEPTH (gbr_pkg::DESC_DEPTH)
	) u_desc_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (dq_push),
		.wdata  (dq_wdata),
		.full   (dq_full),
		.pop    (dq_pop),
		.rdata  (dq_rdata),
		.empty  (dq_empty)
	);

	gbr_back #(
		.RADIUS     (RADIUS),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.DESC_W     (DESC_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (!dq_empty),
		.desc       (dq_rdata),
		.desc_pop   (dq_pop),
		.taps       (taps_q),
		.h_eff      (h_eff),
		.res_full   (rq_full),
		.res_push   (rq_push),
		.res        (rq_wdata)
	);

	gbr_fifo #(
		.WIDTH (RES_W),
		.DEPTH (gbr_pkg::RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_wdata),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	assign rq_head     = gbr_pkg::res_t'(rq_rdata);
	assign red_out     = rq_head.red;
	assign green_out   = rq_head.green;
	assign blue_out    = rq_head.blue;
	assign out_row     = rq_head.row;
	assign out_col     = rq_head.col;
	assign last_of_run = rq_head.last;

endmodule
